// ----- hw/rtl/dnsenc_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsenc_pkg
// Types and constants shared by the query message encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsenc_pkg;

  // label length field, wide enough for any supported label capacity
  localparam int LEN_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  // byte positions inside the fixed parts of the message
  localparam logic [LEN_W-1:0] HDR_LAST_IDX = 6'd11;
  localparam logic [LEN_W-1:0] END_LAST_IDX = 6'd4;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESPONSE_FLAG       = 3'd0,
    REG_OPERATION_CODE      = 3'd1,
    REG_AUTHORITATIVE_FLAG  = 3'd2,
    REG_TRUNCATED_FLAG      = 3'd3,
    REG_RECURSION_DESIRED   = 3'd4,
    REG_RECURSION_AVAILABLE = 3'd5,
    REG_RESERVED_BITS       = 3'd6,
    REG_RESPONSE_CODE       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_LABEL  = 2'd1,
    CMD_END    = 2'd2
  } cmd_op_t;

  // work handed from the front to the back
  typedef struct packed {
    cmd_op_t          op;
    logic             flag;
    logic [15:0]      query_id;
    logic [15:0]      question_count;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // label buffer write from the front
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } label_wr_t;

  typedef struct packed {
    logic       response_flag;
    logic [3:0] operation_code;
    logic       authoritative_flag;
    logic       truncated_flag;
    logic       recursion_desired;
    logic       recursion_available;
    logic [2:0] reserved_bits;
    logic [3:0] response_code;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dnsenc_front.sv -----
// ----------------------------------------------------------------------------
// dnsenc_front
// Accepts input transactions, tracks the label being built, writes label
// characters and queues header, label and end-of-question commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsenc_front #(
  parameter int LABEL_CAPACITY = 63
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire  [39:0]             s_tdata,
  input  wire                     s_tlast,
  input  wire  [1:0]              s_tuser,
  input  wire                     q_full,
  output logic                    q_push,
  output dnsenc_pkg::cmd_t        q_cmd,
  output dnsenc_pkg::label_wr_t   label_wr,
  input  wire                     flush_done
);
  import dnsenc_pkg::*;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic             ovf;
  logic             ovf_next;
  logic             flush_busy;
  logic             flush_busy_next;

  logic             accept;
  logic             pending;
  logic [LEN_W-1:0] grown_len;
  logic             grown_ovf;
  logic [7:0]       name_char;

  assign name_char = s_tdata[39:32];
  assign s_tready  = !q_full && !flush_busy;
  assign accept    = s_tvalid && s_tready;
  assign pending   = (len != '0) || ovf;

  // label state and command generation
  always_comb begin
    len_next        = len;
    ovf_next        = ovf;
    flush_busy_next = flush_busy;
    q_push          = 1'b0;
    q_cmd.op             = CMD_HEADER;
    q_cmd.flag           = pending;
    q_cmd.query_id       = s_tdata[15:0];
    q_cmd.question_count = s_tdata[31:16];
    q_cmd.len            = len;
    label_wr.en   = 1'b0;
    label_wr.addr = len;
    label_wr.data = name_char;
    grown_len     = len;
    grown_ovf     = ovf;

    if (flush_done) begin
      flush_busy_next = 1'b0;
    end

    if (accept) begin
      unique case (kind_t'(s_tuser))
        KIND_HEADER: begin
          q_push   = 1'b1;
          q_cmd.op = CMD_HEADER;
          len_next = '0;
          ovf_next = 1'b0;
        end
        KIND_CHAR: begin
          if (name_char == DOT_CHAR) begin
            q_push          = 1'b1;
            q_cmd.op        = CMD_LABEL;
            q_cmd.flag      = ovf;
            q_cmd.len       = len;
            len_next        = '0;
            ovf_next        = 1'b0;
            flush_busy_next = 1'b1;
          end else begin
            // append while room remains, otherwise mark truncation
            if (len < LEN_W'(LABEL_CAPACITY)) begin
              label_wr.en = 1'b1;
              grown_len   = len + 1'b1;
            end else begin
              grown_ovf = 1'b1;
            end
            len_next = grown_len;
            ovf_next = grown_ovf;
            if (s_tlast) begin
              q_push          = 1'b1;
              q_cmd.op        = CMD_LABEL;
              q_cmd.flag      = grown_ovf;
              q_cmd.len       = grown_len;
              len_next        = '0;
              ovf_next        = 1'b0;
              flush_busy_next = 1'b1;
            end
          end
        end
        KIND_END: begin
          q_push   = 1'b1;
          q_cmd.op = CMD_END;
          len_next = '0;
          ovf_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      ovf        <= 1'b0;
      flush_busy <= 1'b0;
    end else begin
      len        <= len_next;
      ovf        <= ovf_next;
      flush_busy <= flush_busy_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dnsenc_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// dnsenc_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsenc_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  dnsenc_pkg::cmd_t  push_cmd,
  output logic              full,
  input  wire               pop,
  output dnsenc_pkg::cmd_t  pop_cmd,
  output logic              empty
);
  import dnsenc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dnsenc_back.sv -----
// ----------------------------------------------------------------------------
// dnsenc_back
// Executes each queued command at one output byte per cycle while m_tready allows; holds the label buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsenc_back #(
  parameter int LABEL_CAPACITY = 63
) (
  input  wire                     clk,
  input  wire                     rst,
  input  dnsenc_pkg::cfg_t        cfg,
  input  dnsenc_pkg::label_wr_t   label_wr,
  input  wire                     q_empty,
  input  dnsenc_pkg::cmd_t        q_cmd,
  output logic                    q_pop,
  output logic                    flush_done,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [7:0]              m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser
);
  import dnsenc_pkg::*;

  localparam int ADDR_W = (LABEL_CAPACITY > 1) ? $clog2(LABEL_CAPACITY) : 1;

  logic [7:0] label_mem [LABEL_CAPACITY];
  logic [7:0] rd_data;

  cmd_t             cmd;
  logic             active;
  logic [LEN_W-1:0] idx;

  logic             s1_valid;
  logic             s1_from_mem;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             s1_flag;

  logic             out_adv;
  logic             s1_free;
  logic             issue;
  logic [7:0]       gen_byte;
  logic             gen_from_mem;
  logic             gen_last;
  logic [LEN_W-1:0] rd_idx;
  logic [7:0]       flags1;
  logic [7:0]       flags2;

  assign flags1 = {cfg.response_flag, cfg.operation_code, cfg.authoritative_flag,
                   cfg.truncated_flag, cfg.recursion_desired};
  assign flags2 = {cfg.recursion_available, cfg.reserved_bits, cfg.response_code};

  assign out_adv = !m_tvalid || m_tready;
  assign s1_free = !s1_valid || out_adv;
  assign issue   = active && s1_free;
  assign q_pop   = !active && !q_empty;
  assign rd_idx  = idx - 1'b1;

  // byte generator for the current command
  always_comb begin
    gen_byte     = 8'h00;
    gen_from_mem = 1'b0;
    gen_last     = 1'b0;
    unique case (cmd.op)
      CMD_HEADER: begin
        unique case (idx)
          6'd0:    gen_byte = cmd.query_id[15:8];
          6'd1:    gen_byte = cmd.query_id[7:0];
          6'd2:    gen_byte = flags1;
          6'd3:    gen_byte = flags2;
          6'd4:    gen_byte = cmd.question_count[15:8];
          6'd5:    gen_byte = cmd.question_count[7:0];
          default: gen_byte = 8'h00;
        endcase
        gen_last = (idx == HDR_LAST_IDX);
      end
      CMD_LABEL: begin
        if (idx == '0) begin
          gen_byte = {{(8 - LEN_W){1'b0}}, cmd.len};
        end else begin
          gen_from_mem = 1'b1;
        end
        gen_last = (idx == cmd.len);
      end
      CMD_END: begin
        gen_byte = ((idx == 6'd2) || (idx == 6'd4)) ? 8'h01 : 8'h00;
        gen_last = (idx == END_LAST_IDX);
      end
      default: begin
        gen_last = 1'b1;
      end
    endcase
  end

  assign flush_done = issue && gen_last && (cmd.op == CMD_LABEL);

  // label buffer
  always_ff @(posedge clk) begin
    if (label_wr.en) begin
      label_mem[label_wr.addr[ADDR_W-1:0]] <= label_wr.data;
    end
    if (issue && gen_from_mem) begin
      rd_data <= label_mem[rd_idx[ADDR_W-1:0]];
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (q_pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
      if (gen_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
  end

  // byte stage aligned with the buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_from_mem <= gen_from_mem;
      s1_byte     <= gen_byte;
      s1_last     <= gen_last;
      s1_flag     <= cmd.flag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      m_tdata <= s1_from_mem ? rd_data : s1_byte;
      m_tlast <= s1_last;
      m_tuser <= s1_flag;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dns_query_message_encoder_top.sv -----
// ----------------------------------------------------------------------------
// dns_query_message_encoder_top
// Turns header, name character and end-of-question transactions into the
// wire bytes of a DNS query message.
// ----------------------------------------------------------------------------
// A header transaction emits 12 bytes, an end-of-question transaction 5 bytes,
// and a label flush (dot or last character) emits the length byte plus the
// kept characters; each command leaves at one byte per cycle while m_tready is
// high, and the back end fetches each command from the command queue. While a
// label flush is still reading the label buffer the input side holds tready
// low, so the next transaction waits for that flush. Labels beyond
// LABEL_CAPACITY characters are cut and flagged in m_tuser, which also flags
// a dropped partial label on header and end-of-question bytes; m_tlast marks
// the final byte caused by one input transaction.
`default_nettype none

module dns_query_message_encoder_top #(
  parameter int LABEL_CAPACITY = 63
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // config write port
  input  wire                                  cfg_we,
  input  wire  [dnsenc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [dnsenc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [39:0]                          s_tdata,  // query_id, question_count, name_char
  input  wire                                  s_tlast,  // last_char
  input  wire  [1:0]                           s_tuser,  // kind
  // output stream
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [7:0]                           m_tdata,  // out_byte
  output logic                                 m_tlast,  // last_byte
  output logic                                 m_tuser   // label_too_long
);
  import dnsenc_pkg::*;

  cfg_t      cfg;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  label_wr_t label_wr;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  logic      flush_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.response_flag       <= 1'b0;
      cfg.operation_code      <= 4'd0;
      cfg.authoritative_flag  <= 1'b0;
      cfg.truncated_flag      <= 1'b0;
      cfg.recursion_desired   <= 1'b1;
      cfg.recursion_available <= 1'b0;
      cfg.reserved_bits       <= 3'd0;
      cfg.response_code       <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RESPONSE_FLAG:       cfg.response_flag       <= cfg_data[0];
        REG_OPERATION_CODE:      cfg.operation_code      <= cfg_data[3:0];
        REG_AUTHORITATIVE_FLAG:  cfg.authoritative_flag  <= cfg_data[0];
        REG_TRUNCATED_FLAG:      cfg.truncated_flag      <= cfg_data[0];
        REG_RECURSION_DESIRED:   cfg.recursion_desired   <= cfg_data[0];
        REG_RECURSION_AVAILABLE: cfg.recursion_available <= cfg_data[0];
        REG_RESERVED_BITS:       cfg.reserved_bits       <= cfg_data[2:0];
        REG_RESPONSE_CODE:       cfg.response_code       <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  dnsenc_front #(
    .LABEL_CAPACITY(LABEL_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .label_wr  (label_wr),
    .flush_done(flush_done)
  );

  dnsenc_cmd_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (pop_cmd),
    .empty   (q_empty)
  );

  dnsenc_back #(
    .LABEL_CAPACITY(LABEL_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .label_wr  (label_wr),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .flush_done(flush_done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_dns_query_message_encoder_top.sv -----
// ----------------------------------------------------------------------------
// tb_dns_query_message_encoder_top
// Self-checking bench for the query message encoder: a directed table of headers,
// labels, overflows and dropped labels, then random query messages under several
// flag settings, with random gaps on both streams and one long output hold-off.
// Output bytes are compared with a local encoder model or with bytes typed into a row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dns_query_message_encoder_top;
  import dnsenc_pkg::*;

  localparam int LABEL_CAP = 63;
  localparam int NUM_REGS = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] DASH_CHAR = 8'h2d;
  localparam int GAP_MAX = 11;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 20;
  localparam int NUM_PHASES = 4;
  localparam int CYCLE_LIMIT = 1_000_000;

  // one encoded byte as seen on the output stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       too_long;
  } msg_byte_t;

  // bytes typed into a directed row, first byte in the top bits
  typedef struct packed {
    logic        en;
    logic [3:0]  count;
    logic [95:0] bytes;
    logic        too_long;
  } fixed_bytes_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [15:0]  query_id;
    logic [15:0]  question_count;
    logic [7:0]   name_char;
    logic         last_char;
    logic [6:0]   rep_count;
    fixed_bytes_t fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;   // query_id, question_count, name_char
  logic s_tlast = 1'b0;        // last_char
  logic [1:0] s_tuser = '0;    // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;         // out_byte
  logic m_tlast;               // last_byte
  logic m_tuser;               // label_too_long

  // encoder model state
  logic [7:0] label_buf [LABEL_CAP];
  logic [5:0] label_len = '0;
  logic overflow_seen = 1'b0;
  cfg_t cfg_shadow;

  msg_byte_t expected_bytes [$];
  msg_byte_t item_bytes [$];
  fixed_bytes_t fixed_pending [$];
  stim_row_t dir_rows [$];
  logic [3:0] reg_vals [NUM_REGS];

  int mismatch_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int hold_cycles = 0;
  bit send_burst = 1'b0;

  dns_query_message_encoder_top #(.LABEL_CAPACITY(LABEL_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // ---------------------------------------------------------------------------
  // encoder model
  // ---------------------------------------------------------------------------
  function automatic void emit(input logic [7:0] b, input logic fl);
    msg_byte_t w;
    w.data = b;
    w.last = 1'b0;
    w.too_long = fl;
    item_bytes.insert(item_bytes.size(), w);
  endfunction

  // clear a partial label, tell whether one was there
  function automatic logic take_pending();
    logic was_pending;
    was_pending = (label_len != '0) || overflow_seen;
    label_len = '0;
    overflow_seen = 1'b0;
    return was_pending;
  endfunction

  function automatic void flush_label();
    logic fl;
    fl = overflow_seen;
    emit({2'b00, label_len}, fl);
    for (int i = 0; i < label_len; i++) emit(label_buf[i], fl);
    label_len = '0;
    overflow_seen = 1'b0;
  endfunction

  function automatic void encode_item(input logic [1:0] kind, input logic [15:0] qid,
                                      input logic [15:0] qdc, input logic [7:0] ch,
                                      input logic lst);
    logic fl;
    item_bytes.delete();
    case (kind)
      KIND_HEADER: begin
        fl = take_pending();
        emit(qid[15:8], fl);
        emit(qid[7:0], fl);
        emit({cfg_shadow.response_flag, cfg_shadow.operation_code,
              cfg_shadow.authoritative_flag, cfg_shadow.truncated_flag,
              cfg_shadow.recursion_desired}, fl);
        emit({cfg_shadow.recursion_available, cfg_shadow.reserved_bits,
              cfg_shadow.response_code}, fl);
        emit(qdc[15:8], fl);
        emit(qdc[7:0], fl);
        repeat (6) emit(8'h00, fl);
      end
      KIND_CHAR: begin
        if (ch == DOT_CHAR) begin
          flush_label();
        end else begin
          // characters past capacity are dropped but remembered
          if (label_len < LABEL_CAP) begin
            label_buf[label_len] = ch;
            label_len = label_len + 6'd1;
          end else begin
            overflow_seen = 1'b1;
          end
          if (lst) flush_label();
        end
      end
      KIND_END: begin
        // root byte, type A, class IN
        fl = take_pending();
        emit(8'h00, fl);
        emit(8'h00, fl);
        emit(8'h01, fl);
        emit(8'h00, fl);
        emit(8'h01, fl);
      end
      default: begin
      end
    endcase
    if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic void shadow_write(input cfg_reg_t idx, input logic [3:0] v);
    case (idx)
      REG_RESPONSE_FLAG:       cfg_shadow.response_flag = v[0];
      REG_OPERATION_CODE:      cfg_shadow.operation_code = v;
      REG_AUTHORITATIVE_FLAG:  cfg_shadow.authoritative_flag = v[0];
      REG_TRUNCATED_FLAG:      cfg_shadow.truncated_flag = v[0];
      REG_RECURSION_DESIRED:   cfg_shadow.recursion_desired = v[0];
      REG_RECURSION_AVAILABLE: cfg_shadow.recursion_available = v[0];
      REG_RESERVED_BITS:       cfg_shadow.reserved_bits = v[2:0];
      REG_RESPONSE_CODE:       cfg_shadow.response_code = v;
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stream monitors: accepted input feeds the model, output bytes are checked
  // ---------------------------------------------------------------------------
  task automatic accept_item();
    fixed_bytes_t fx;
    msg_byte_t b;
    fx = '0;
    if (fixed_pending.size() > 0) fx = fixed_pending.pop_front();
    encode_item(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[39:32], s_tlast);
    if (fx.en) begin
      item_bytes.delete();
      for (int i = 0; i < fx.count; i++) begin
        b.data = fx.bytes[95 - 8 * i -: 8];
        b.last = (i == fx.count - 1);
        b.too_long = fx.too_long;
        item_bytes.insert(item_bytes.size(), b);
      end
    end
    foreach (item_bytes[i]) expected_bytes.insert(expected_bytes.size(), item_bytes[i]);
  endtask

  task automatic check_byte();
    msg_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h", m_tdata));
    end else begin
      want = expected_bytes.pop_front();
      if (m_tdata !== want.data)
        report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last_byte %b, want %b", m_tlast, want.last));
      if (m_tuser !== want.too_long)
        report_mismatch($sformatf("label_too_long %b, want %b", m_tuser, want.too_long));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) accept_item();
      if (m_tvalid && m_tready) check_byte();
    end
  end

  // output side: random stalls, zero-stall stretches, one long hold-off
  initial begin
    int stall;
    int taken;
    bit ready_burst;
    taken = 0;
    ready_burst = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = ready_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
      if (taken % 32 == 0) ready_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] kind, input logic [15:0] qid,
                           input logic [15:0] qdc, input logic [7:0] ch,
                           input logic lst, input fixed_bytes_t fx);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ch, qdc, qid};
    s_tlast <= lst;
    s_tuser <= kind;
    fixed_pending.insert(fixed_pending.size(), fx);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // idle the input, let every byte come out, then let the block run idle before the next phase
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= reg_vals[i];
      shadow_write(cfg_reg_t'(i), reg_vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_label(input int len, input logic final_label);
    logic [7:0] c;
    logic mark_on_char;
    mark_on_char = final_label && (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == DOT_CHAR) c = DASH_CHAR;
      send_item(KIND_CHAR, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), c,
                mark_on_char && (i == len - 1), '0);
    end
    // otherwise close with a dot, marked last on the final label
    if (!mark_on_char)
      send_item(KIND_CHAR, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                DOT_CHAR, final_label, '0);
  endtask

  // any kind, stray dots, unfinished labels
  task automatic send_noise();
    logic [7:0] c;
    c = ($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255));
    send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), c, 1'($urandom_range(0, 1)), '0);
  endtask

  task automatic send_message();
    int n_q;
    int n_l;
    int pick;
    int len;
    send_burst = ($urandom_range(0, 3) == 0);
    send_item(KIND_HEADER, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), '0);
    n_q = $urandom_range(1, 3);
    for (int q = 0; q < n_q; q++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      n_l = $urandom_range(1, 4);
      for (int l = 0; l < n_l; l++) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) len = 0;
        else if (pick == 1) len = $urandom_range(60, 70);
        else len = $urandom_range(1, 6);
        send_label(len, l == n_l - 1);
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      send_item(KIND_END, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), '0);
    end
  endtask

  function automatic stim_row_t plain_row(input logic [1:0] kind, input logic [15:0] qid,
                                          input logic [15:0] qdc, input logic [7:0] ch,
                                          input logic lst, input int rep);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.query_id = qid;
    r.question_count = qdc;
    r.name_char = ch;
    r.last_char = lst;
    r.rep_count = 7'(rep);
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input logic [1:0] kind, input logic [15:0] qid,
                                          input logic [15:0] qdc, input logic [7:0] ch,
                                          input logic lst, input int cnt,
                                          input logic [95:0] bytes, input logic fl);
    stim_row_t r;
    r = plain_row(kind, qid, qdc, ch, lst, 1);
    r.fixed.en = 1'b1;
    r.fixed.count = 4'(cnt);
    r.fixed.bytes = bytes;
    r.fixed.too_long = fl;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    cfg_shadow = '0;
    cfg_shadow.recursion_desired = 1'b1;

    // directed table: headers at the field extremes after reset, then an end of question
    add_row(fixed_row(KIND_HEADER, 16'hffff, 16'h0000, 8'hff, 1'b1, 12,
                      {16'hffff, 8'h01, 8'h00, 16'h0000, 48'h0}, 1'b0));
    add_row(fixed_row(KIND_HEADER, 16'h0000, 16'hffff, 8'h00, 1'b0, 12,
                      {16'h0000, 8'h01, 8'h00, 16'hffff, 48'h0}, 1'b0));
    add_row(fixed_row(KIND_END, 16'hffff, 16'hffff, 8'hff, 1'b1, 5,
                      {40'h00_0001_0001, 56'h0}, 1'b0));
    // empty label
    add_row(fixed_row(KIND_CHAR, 16'h0000, 16'h0000, DOT_CHAR, 1'b0, 1,
                      {8'h00, 88'h0}, 1'b0));
    // ordinary label, then character extremes flushed by a non-dot last character
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h77, 1'b0, 3));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, DOT_CHAR, 1'b0, 1));
    add_row(plain_row(KIND_CHAR, 16'hffff, 16'hffff, 8'h00, 1'b0, 1));
    add_row(plain_row(KIND_CHAR, 16'hffff, 16'hffff, 8'hff, 1'b1, 1));
    // trailing dot
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h61, 1'b0, 1));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, DOT_CHAR, 1'b1, 1));
    add_row(fixed_row(KIND_END, 16'h0000, 16'h0000, 8'h00, 1'b0, 5,
                      {40'h00_0001_0001, 56'h0}, 1'b0));
    // partial label dropped by a header and by an end of question
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h78, 1'b0, 1));
    add_row(fixed_row(KIND_HEADER, 16'h1234, 16'h0001, 8'h00, 1'b0, 12,
                      {16'h1234, 8'h01, 8'h00, 16'h0001, 48'h0}, 1'b1));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h79, 1'b0, 1));
    add_row(fixed_row(KIND_END, 16'h0000, 16'h0000, DOT_CHAR, 1'b0, 5,
                      {40'h00_0001_0001, 56'h0}, 1'b1));
    // undefined kind is ignored
    add_row(fixed_row(KIND_UNUSED, 16'hffff, 16'hffff, 8'hff, 1'b1, 0, 96'h0, 1'b0));
    // label of exactly the capacity
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h71, 1'b0, 62));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h72, 1'b1, 1));
    // overflow flushed by a dot and by a last character
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h7a, 1'b0, 64));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, DOT_CHAR, 1'b0, 1));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h7a, 1'b0, 63));
    add_row(plain_row(KIND_CHAR, 16'h0000, 16'h0000, 8'h6b, 1'b1, 1));
    add_row(fixed_row(KIND_END, 16'h0000, 16'h0000, 8'h00, 1'b0, 5,
                      {40'h00_0001_0001, 56'h0}, 1'b0));
    add_row(plain_row(KIND_UNUSED, 16'h0000, 16'h0000, 8'h00, 1'b0, 1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part with reset flag settings
    foreach (dir_rows[r]) begin
      send_burst = (r >= 8 && r < 16);
      for (int k = 0; k < dir_rows[r].rep_count; k++)
        send_item(dir_rows[r].kind, dir_rows[r].query_id, dir_rows[r].question_count,
                  dir_rows[r].name_char, dir_rows[r].last_char, dir_rows[r].fixed);
    end
    finish_phase();

    // random messages: all flags high, all low, then two random settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < NUM_REGS; i++)
        reg_vals[i] = (p == 0) ? 4'hf : (p == 1) ? 4'h0 : 4'($urandom_range(0, 15));
      write_config();
      if (p == 1) hold_cycles = HOLD_CYCLES;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) send_message();
      finish_phase();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
